>>> hw/rtl/qslerp_pkg.sv
// Package for the quaternion slerp core: fixed-point widths, pipeline stage map,
// the CORDIC arctangent table, item mode codes and the pipeline item type.
// No dependencies.
package qslerp_pkg;

	localparam int CW      = 16;
	localparam int FW      = 15;
	localparam int STEPS   = 30;
	localparam int SQRT_N  = 31;
	localparam int QW      = 32;
	localparam int XW      = 34;
	localparam int NW      = 31;
	localparam int DW      = 30;
	localparam int PW      = 50;
	localparam int SW      = 52;

	localparam int ST_SQRT = 4;
	localparam int ST_VEC  = ST_SQRT + SQRT_N;
	localparam int ST_ANG  = ST_VEC + STEPS;
	localparam int ST_ROT  = ST_ANG + 1;
	localparam int ST_DIV  = ST_ROT + STEPS;
	localparam int ST_MUL  = ST_DIV + QW;
	localparam int ST_OUT  = ST_MUL + 1;

	localparam logic [36:0]          NEAR_ONE = 37'd1073731072;
	localparam logic signed [34:0]   DOT_ONE  = 35'sd268435456;
	localparam logic signed [XW-1:0] INV_GAIN = 34'sd652032874;
	localparam logic [FW:0]          T_ONE    = 16'd32768;
	localparam logic signed [SW-1:0] SAT_LIM  = 52'sd16384;

	localparam logic [29:0] ARC_TAB [STEPS] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
	};

	typedef enum logic [1:0] {
		MODE_START,
		MODE_SLERP,
		MODE_LERP
	} mode_t;

	typedef struct packed {
		mode_t                 mode;
		logic [3:0][CW-1:0]    s;
		logic [3:0][CW:0]      e;
		logic [FW:0]           t;
	} item_t;

	function automatic logic [CW-1:0] sat_comp(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		begin
			if (v > SAT_LIM) begin
				r = SAT_LIM;
			end else if (v < -SAT_LIM) begin
				r = -SAT_LIM;
			end else begin
				r = v;
			end
			return r[CW-1:0];
		end
	endfunction

endpackage

>>> hw/rtl/quaternion_slerp_core.sv
// Quaternion slerp core: fully pipelined spherical linear interpolation, Q1.14 in and out.
// Depends on qslerp_pkg.

// One word enters per clock and busy never rises. Results appear with done in the
// order their words were taken. The depth is set by the one-bit-per-stage
// square root (31 stages), the two 30-stage CORDIC chains and the 32-stage
// quotient of the weights. The receiver must take every result in its done cycle.
module quaternion_slerp_core
	import qslerp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [CW-1:0] start_c0,
	input  logic signed [CW-1:0] start_c1,
	input  logic signed [CW-1:0] start_c2,
	input  logic signed [CW-1:0] start_c3,
	input  logic signed [CW-1:0] end_c0,
	input  logic signed [CW-1:0] end_c1,
	input  logic signed [CW-1:0] end_c2,
	input  logic signed [CW-1:0] end_c3,
	input  logic        [CW-1:0] frac,
	output logic                 done,
	output logic signed [CW-1:0] out_c0,
	output logic signed [CW-1:0] out_c1,
	output logic signed [CW-1:0] out_c2,
	output logic signed [CW-1:0] out_c3
);

	logic                  vld_s [ST_OUT+1];
	item_t                 itm_s [ST_MUL+1];

	logic signed [32:0]    prod_s1 [4];
	logic [DW-1:0]         d_s2;
	logic [DW-1:0]         d_s3;
	logic [2*DW-1:0]       sq_s3;

	logic [60:0]           sqv_s [SQRT_N];
	logic [61:0]           sqr_s [SQRT_N];
	logic [DW-1:0]         sqd_s [SQRT_N];

	logic signed [XW-1:0]  vx_s [STEPS];
	logic signed [XW-1:0]  vy_s [STEPS];
	logic signed [XW-1:0]  vz_s [STEPS];
	logic [NW-1:0]         vsn_s [STEPS];

	logic [32:0]           ath_s;
	logic [32:0]           aa1_s;
	logic [NW-1:0]         asn_s;

	logic signed [XW-1:0]  rx_s [STEPS][2];
	logic signed [XW-1:0]  ry_s [STEPS][2];
	logic signed [XW-1:0]  rz_s [STEPS][2];
	logic [NW-1:0]         rsn_s [STEPS];

	logic [63:0]           drem_s [QW][2];
	logic [QW-1:0]         dq_s [QW][2];
	logic                  dneg_s [QW][2];
	logic [NW-1:0]         dsn_s [QW];

	logic signed [PW-1:0]  ps_s [4];
	logic signed [PW-1:0]  pe_s [4];
	logic [CW-1:0]         res_s [4];

	logic signed [34:0]    dot_c;
	logic [34:0]           dabs_c;
	logic [36:0]           dq_c;
	item_t                 itm2_c;
	logic [FW:0]           tcl_c;

	assign busy = 1'b0;
	assign done = vld_s[ST_OUT];
	assign out_c0 = res_s[0];
	assign out_c1 = res_s[1];
	assign out_c2 = res_s[2];
	assign out_c3 = res_s[3];

	assign tcl_c = (frac > T_ONE) ? T_ONE : frac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		itm_s[0].mode <= MODE_LERP;
		itm_s[0].s    <= {start_c3, start_c2, start_c1, start_c0};
		itm_s[0].e    <= {{end_c3[CW-1], end_c3}, {end_c2[CW-1], end_c2},
			{end_c1[CW-1], end_c1}, {end_c0[CW-1], end_c0}};
		itm_s[0].t    <= tcl_c;
	end

	genvar i;
	generate
		for (i = 1; i <= ST_OUT; i++) begin : g_vld
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
		for (i = 1; i <= ST_MUL; i++) begin : g_itm
			if (i == 2) begin : g_fix
				always_ff @(posedge clk) begin
					itm_s[i] <= itm2_c;
				end
			end else begin : g_pass
				always_ff @(posedge clk) begin
					itm_s[i] <= itm_s[i-1];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s1[k] <= $signed(itm_s[0].s[k]) * $signed(itm_s[0].e[k]);
		end
	end

	always_comb begin
		dot_c = '0;
		for (int k = 0; k < 4; k++) begin
			dot_c = dot_c + {{2{prod_s1[k][32]}}, prod_s1[k]};
		end
		dabs_c = dot_c[34] ? 35'(-dot_c) : 35'(dot_c);
		dq_c = {dabs_c, 2'b00};
		itm2_c = itm_s[1];
		for (int k = 0; k < 4; k++) begin
			itm2_c.e[k] = dot_c[34] ? 17'(-itm_s[1].e[k]) : itm_s[1].e[k];
		end
		if (dot_c == DOT_ONE) begin
			itm2_c.mode = MODE_START;
		end else if (dq_c < NEAR_ONE) begin
			itm2_c.mode = MODE_SLERP;
		end else begin
			itm2_c.mode = MODE_LERP;
		end
	end

	always_ff @(posedge clk) begin
		d_s2  <= dq_c[DW-1:0];
		d_s3  <= d_s2;
		sq_s3 <= d_s2 * d_s2;
	end

	genvar j, u;
	generate
		for (j = 0; j < SQRT_N; j++) begin : g_sqrt
			logic [60:0] v_in;
			logic [61:0] r_in;
			logic [DW-1:0] d_in;
			logic [61:0] bit_c;
			logic [61:0] tr_c;
			if (j == 0) begin : g_init
				assign v_in = (61'd1 << 60) - {1'b0, sq_s3};
				assign r_in = '0;
				assign d_in = d_s3;
			end else begin : g_prev
				assign v_in = sqv_s[j-1];
				assign r_in = sqr_s[j-1];
				assign d_in = sqd_s[j-1];
			end
			assign bit_c = 62'd1 << (2 * (SQRT_N - 1 - j));
			assign tr_c  = r_in + bit_c;
			always_ff @(posedge clk) begin
				sqd_s[j] <= d_in;
				if ({1'b0, v_in} >= tr_c) begin
					sqv_s[j] <= v_in - tr_c[60:0];
					sqr_s[j] <= (r_in >> 1) + bit_c;
				end else begin
					sqv_s[j] <= v_in;
					sqr_s[j] <= r_in >> 1;
				end
			end
		end

		for (j = 0; j < STEPS; j++) begin : g_vec
			logic signed [XW-1:0] x_in, y_in, z_in, arc_c;
			logic [NW-1:0] sn_in;
			if (j == 0) begin : g_init
				logic [NW-1:0] root_c;
				assign root_c = sqr_s[SQRT_N-1][NW-1:0];
				assign sn_in = (root_c == '0) ? NW'(1) : root_c;
				assign x_in  = {4'b0, sqd_s[SQRT_N-1]};
				assign y_in  = {3'b0, sn_in};
				assign z_in  = '0;
			end else begin : g_prev
				assign sn_in = vsn_s[j-1];
				assign x_in  = vx_s[j-1];
				assign y_in  = vy_s[j-1];
				assign z_in  = vz_s[j-1];
			end
			assign arc_c = {4'b0, ARC_TAB[j]};
			always_ff @(posedge clk) begin
				vsn_s[j] <= sn_in;
				if (y_in > 0) begin
					vx_s[j] <= x_in + (y_in >>> j);
					vy_s[j] <= y_in - (x_in >>> j);
					vz_s[j] <= z_in + arc_c;
				end else begin
					vx_s[j] <= x_in - (y_in >>> j);
					vy_s[j] <= y_in + (x_in >>> j);
					vz_s[j] <= z_in - arc_c;
				end
			end
		end
	endgenerate

	logic [32:0] th_c;
	logic [48:0] tht_c;
	assign th_c  = vz_s[STEPS-1][XW-1] ? 33'd0 : vz_s[STEPS-1][32:0];
	assign tht_c = th_c * itm_s[ST_ANG-1].t;

	always_ff @(posedge clk) begin
		ath_s <= th_c;
		aa1_s <= tht_c[47:15];
		asn_s <= vsn_s[STEPS-1];
	end

	generate
		for (j = 0; j < STEPS; j++) begin : g_rot
			logic [NW-1:0] sn_in;
			logic signed [XW-1:0] arc_c;
			if (j == 0) begin : g_init
				assign sn_in = asn_s;
			end else begin : g_prev
				assign sn_in = rsn_s[j-1];
			end
			assign arc_c = {4'b0, ARC_TAB[j]};
			always_ff @(posedge clk) begin
				rsn_s[j] <= sn_in;
			end
			for (u = 0; u < 2; u++) begin : g_unit
				logic signed [XW-1:0] x_in, y_in, z_in;
				if (j == 0) begin : g_init
					assign x_in = INV_GAIN;
					assign y_in = '0;
					if (u == 0) begin : g_a0
						assign z_in = $signed({1'b0, ath_s}) - $signed({1'b0, aa1_s});
					end else begin : g_a1
						assign z_in = {1'b0, aa1_s};
					end
				end else begin : g_prev
					assign x_in = rx_s[j-1][u];
					assign y_in = ry_s[j-1][u];
					assign z_in = rz_s[j-1][u];
				end
				always_ff @(posedge clk) begin
					if (z_in >= 0) begin
						rx_s[j][u] <= x_in - (y_in >>> j);
						ry_s[j][u] <= y_in + (x_in >>> j);
						rz_s[j][u] <= z_in - arc_c;
					end else begin
						rx_s[j][u] <= x_in + (y_in >>> j);
						ry_s[j][u] <= y_in - (x_in >>> j);
						rz_s[j][u] <= z_in + arc_c;
					end
				end
			end
		end

		for (j = 0; j < QW; j++) begin : g_div
			logic [NW-1:0] sn_in;
			logic [63:0] dsh_c;
			if (j == 0) begin : g_init
				assign sn_in = rsn_s[STEPS-1];
			end else begin : g_prev
				assign sn_in = dsn_s[j-1];
			end
			assign dsh_c = {33'd0, sn_in} << (QW - 1 - j);
			always_ff @(posedge clk) begin
				dsn_s[j] <= sn_in;
			end
			for (u = 0; u < 2; u++) begin : g_unit
				logic [63:0] rem_in;
				logic [QW-1:0] q_in;
				logic neg_in;
				if (j == 0) begin : g_init
					logic signed [XW-1:0] y_c;
					logic [XW-1:0] mag_c;
					assign y_c    = ry_s[STEPS-1][u];
					assign mag_c  = y_c[XW-1] ? XW'(-y_c) : XW'(y_c);
					assign rem_in = {mag_c, 30'd0};
					assign q_in   = '0;
					assign neg_in = y_c[XW-1];
				end else begin : g_prev
					assign rem_in = drem_s[j-1][u];
					assign q_in   = dq_s[j-1][u];
					assign neg_in = dneg_s[j-1][u];
				end
				always_ff @(posedge clk) begin
					dneg_s[j][u] <= neg_in;
					if (rem_in >= dsh_c) begin
						drem_s[j][u] <= rem_in - dsh_c;
						dq_s[j][u]   <= q_in | (QW'(1) << (QW - 1 - j));
					end else begin
						drem_s[j][u] <= rem_in;
						dq_s[j][u]   <= q_in;
					end
				end
			end
		end
	endgenerate

	logic signed [32:0] w_c [2];
	logic signed [32:0] wa_c, wb_c;
	item_t mi_c;

	always_comb begin
		mi_c = itm_s[ST_MUL-1];
		for (int k = 0; k < 2; k++) begin
			w_c[k] = dneg_s[QW-1][k] ? -$signed({1'b0, dq_s[QW-1][k]})
				: $signed({1'b0, dq_s[QW-1][k]});
		end
		if (mi_c.mode == MODE_SLERP) begin
			wa_c = w_c[0];
			wb_c = w_c[1];
		end else begin
			wa_c = $signed({17'd0, 16'(T_ONE - mi_c.t)});
			wb_c = $signed({17'd0, mi_c.t});
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			ps_s[k] <= PW'($signed(mi_c.s[k])) * PW'(wa_c);
			pe_s[k] <= PW'($signed(mi_c.e[k])) * PW'(wb_c);
		end
	end

	logic signed [SW-1:0] sum_c [4];
	logic signed [SW-1:0] val_c [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum_c[k] = SW'(ps_s[k]) + SW'(pe_s[k]);
			unique case (itm_s[ST_MUL].mode)
				MODE_START: begin
					val_c[k] = SW'($signed(itm_s[ST_MUL].s[k]));
				end
				MODE_SLERP: begin
					val_c[k] = (sum_c[k] + (SW'(1) <<< 29)) >>> 30;
				end
				default: begin
					val_c[k] = (sum_c[k] + (SW'(1) <<< 14)) >>> 15;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			res_s[k] <= sat_comp(val_c[k]);
		end
	end

endmodule

>>> tb/quaternion_slerp_core_tb.sv
// Testbench for quaternion_slerp_core: random and directed quaternion pairs are
// compared against a fixed-point slerp predictor. Depends on qslerp_pkg and the core.
module quaternion_slerp_core_tb;
	import qslerp_pkg::*;

	localparam int LATENCY = 129;
	localparam int N_RANDOM = 1250;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint NEAR_Q30 = 64'sd1073731072;
	localparam longint GAIN_Q30 = 64'sd652032874;

	typedef struct {
		logic signed [CW-1:0] s [4];
		logic signed [CW-1:0] e [4];
		logic [CW-1:0] frac;
		bit hold;
	} pair_word_t;

	typedef struct {
		logic signed [CW-1:0] c [4];
	} quat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CW-1:0] start_c0 = '0, start_c1 = '0, start_c2 = '0, start_c3 = '0;
	logic signed [CW-1:0] end_c0 = '0, end_c1 = '0, end_c2 = '0, end_c3 = '0;
	logic [CW-1:0] frac = '0;
	logic done;
	logic signed [CW-1:0] out_c0, out_c1, out_c2, out_c3;

	pair_word_t pending_words [$];
	quat_t expected_quats [$];
	pair_word_t driven_word;
	int gap_left = 0;
	int words_sent = 0;
	int n_errors = 0;
	int cycle_count = 0;
	bit stimulus_done = 0;

	quaternion_slerp_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_c0(start_c0), .start_c1(start_c1), .start_c2(start_c2), .start_c3(start_c3),
		.end_c0(end_c0), .end_c1(end_c1), .end_c2(end_c2), .end_c3(end_c3),
		.frac(frac), .done(done),
		.out_c0(out_c0), .out_c1(out_c1), .out_c2(out_c2), .out_c3(out_c3)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint cordic_angle(longint y, longint x);
		longint z;
		longint dx;
		longint dy;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx; y = y - dy; z = z + longint'(ARC_TAB[i]);
			end else begin
				x = x - dx; y = y + dy; z = z - longint'(ARC_TAB[i]);
			end
		end
		return z;
	endfunction

	function automatic longint cordic_sine(longint z);
		longint x;
		longint y;
		longint dx;
		longint dy;
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - longint'(ARC_TAB[i]);
			end else begin
				x = x + dx; y = y - dy; z = z + longint'(ARC_TAB[i]);
			end
		end
		return y;
	endfunction

	function automatic quat_t slerp_predict(pair_word_t w);
		quat_t q;
		longint s [4];
		longint e [4];
		longint r [4];
		longint t;
		longint dot;
		longint d;
		longint sn;
		longint th;
		longint a0;
		longint a1;
		longint w0;
		longint w1;
		dot = 0;
		for (int k = 0; k < 4; k++) begin
			s[k] = w.s[k];
			e[k] = w.e[k];
			dot = dot + s[k] * e[k];
		end
		t = longint'(w.frac);
		if (t > 32768) t = 32768;
		if (dot == 64'sd268435456) begin
			for (int k = 0; k < 4; k++) r[k] = s[k];
		end else begin
			if (dot < 0) begin
				dot = -dot;
				for (int k = 0; k < 4; k++) e[k] = -e[k];
			end
			d = dot <<< 2;
			if (d < NEAR_Q30) begin
				sn = longint'(isqrt(64'd1 << 60) == 0 ? 0 : isqrt((64'd1 << 60) - d * d));
				if (sn == 0) sn = 1;
				th = cordic_angle(sn, d);
				if (th < 0) th = 0;
				a1 = (th * t) >>> FW;
				a0 = th - a1;
				w0 = (cordic_sine(a0) * (64'sd1 <<< 30)) / sn;
				w1 = (cordic_sine(a1) * (64'sd1 <<< 30)) / sn;
				for (int k = 0; k < 4; k++)
					r[k] = (s[k] * w0 + e[k] * w1 + (64'sd1 <<< 29)) >>> 30;
			end else begin
				for (int k = 0; k < 4; k++)
					r[k] = (s[k] * (32768 - t) + e[k] * t + 16384) >>> FW;
			end
		end
		for (int k = 0; k < 4; k++) begin
			if (r[k] > 16384) r[k] = 16384;
			if (r[k] < -16384) r[k] = -16384;
			q.c[k] = r[k][CW-1:0];
		end
		return q;
	endfunction

	task automatic report_mismatch(string what, int idx, int got, int want);
		$display("mismatch in %s[%0d]: got %0d, expected %0d", what, idx, got, want);
		n_errors++;
	endtask

	function automatic pair_word_t make_word(bit raw);
		pair_word_t w;
		real v [4];
		real norm;
		int kind;
		norm = 0.0;
		for (int k = 0; k < 4; k++) begin
			v[k] = real'(int'($urandom_range(0, 65535)) - 32768);
			norm = norm + v[k] * v[k];
		end
		if (norm == 0.0) norm = 1.0;
		norm = $sqrt(norm);
		kind = $urandom_range(0, 9);
		for (int k = 0; k < 4; k++) begin
			w.s[k] = CW'($rtoi(v[k] * 16384.0 / norm));
			if (raw) begin
				w.s[k] = CW'($urandom);
				w.e[k] = CW'($urandom);
			end else if (kind < 3) begin
				w.e[k] = CW'(w.s[k] + int'($urandom_range(0, 8)) - 4);
			end else if (kind < 5) begin
				w.e[k] = CW'(-w.s[k] + int'($urandom_range(0, 400)) - 200);
			end else begin
				w.e[k] = CW'($rtoi(real'(int'($urandom_range(0, 32768)) - 16384)));
			end
		end
		if ($urandom_range(0, 9) == 0) w.frac = CW'($urandom);
		else w.frac = CW'($urandom_range(0, 32768));
		w.hold = 0;
		return w;
	endfunction

	function automatic pair_word_t quat_word(int a0, int a1, int a2, int a3,
			int b0, int b1, int b2, int b3, int t);
		pair_word_t w;
		w.s[0] = CW'(a0); w.s[1] = CW'(a1); w.s[2] = CW'(a2); w.s[3] = CW'(a3);
		w.e[0] = CW'(b0); w.e[1] = CW'(b1); w.e[2] = CW'(b2); w.e[3] = CW'(b3);
		w.frac = CW'(t);
		w.hold = 0;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				expected_quats.push_back(slerp_predict(driven_word));
				words_sent <= words_sent + 1;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_words.size() == 0) begin
				start <= 1'b0;
			end else if (pending_words[0].hold &&
					(expected_quats.size() != 0 || (start && !busy))) begin
				start <= 1'b0;
			end else begin
				driven_word = pending_words.pop_front();
				start <= 1'b1;
				start_c0 <= driven_word.s[0]; start_c1 <= driven_word.s[1];
				start_c2 <= driven_word.s[2]; start_c3 <= driven_word.s[3];
				end_c0 <= driven_word.e[0]; end_c1 <= driven_word.e[1];
				end_c2 <= driven_word.e[2]; end_c3 <= driven_word.e[3];
				frac <= driven_word.frac;
				if (pending_words.size() > 150 && $urandom_range(0, 5) == 0)
					gap_left <= $urandom_range(1, 14);
			end
		end
	end

	always @(posedge clk) begin
		quat_t want;
		logic signed [CW-1:0] got [4];
		if (arst_n && done) begin
			got[0] = out_c0; got[1] = out_c1; got[2] = out_c2; got[3] = out_c3;
			if (expected_quats.size() == 0) begin
				$display("result with no word outstanding");
				n_errors++;
			end else begin
				want = expected_quats.pop_front();
				for (int k = 0; k < 4; k++)
					if (got[k] !== want.c[k])
						report_mismatch("out_c", k, int'(got[k]), int'(want.c[k]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("quaternion_slerp_core test failed");
			$finish;
		end
	end

	initial begin
		pair_word_t w;
		pending_words.push_back(quat_word(16384, 0, 0, 0, 16384, 0, 0, 0, 12345));
		pending_words.push_back(quat_word(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
		pending_words.push_back(quat_word(16384, 0, 0, 0, -16384, 0, 0, 0, 8000));
		pending_words.push_back(quat_word(16384, 0, 0, 0, -16384, 0, 0, 0, 8000));
		pending_words.push_back(quat_word(16384, 0, 0, 0, 0, -16384, 0, 0, 0));
		pending_words.push_back(quat_word(0, 16384, 0, 0, 0, 0, 0, 16384, 32768));
		pending_words.push_back(quat_word(0, 16384, 0, 0, 0, 0, 0, 16384, 65535));
		pending_words.push_back(quat_word(0, 16384, 0, 0, 0, 0, 0, 16384, 40000));
		pending_words.push_back(quat_word(8192, 8192, 8192, 8192, 8192, 8192, 8192, 8193, 16384));
		pending_words.push_back(quat_word(8192, 8192, 8192, 8192, -8192, -8192, -8192, -8191, 9000));
		pending_words.push_back(quat_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1));
		pending_words.push_back(quat_word(-32768, -32768, -32768, -32768,
			32767, 32767, 32767, 32767, 20000));
		pending_words.push_back(quat_word(-32768, 0, 0, 0, -32768, 0, 0, 0, 16384));
		pending_words.push_back(quat_word(16384, 16384, 0, 0, 0, 0, 16384, 16384, 16384));
		pending_words.push_back(quat_word(0, 0, 0, 0, 0, 0, 0, 0, 10000));
		pending_words.push_back(quat_word(0, 0, 0, 0, 16384, 0, 0, 0, 32767));
		pending_words.push_back(quat_word(11585, 11585, 0, 0, 16384, 0, 0, 0, 16384));
		pending_words.push_back(quat_word(-16384, -16384, 16384, -16384,
			16384, 16384, -16384, 16384, 24000));
		for (int i = 0; i < N_RANDOM; i++) begin
			w = make_word($urandom_range(0, 9) == 0);
			if (i == 400 || i == 900) w.hold = 1;
			pending_words.push_back(w);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_words.size() == 0);
		@(posedge clk);
		wait (start == 1'b0 && expected_quats.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (n_errors == 0 && expected_quats.size() == 0) begin
			$display("quaternion_slerp_core test passed");
		end else begin
			$display("quaternion_slerp_core test failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/qslerp_pkg.sv
hw/rtl/quaternion_slerp_core.sv
tb/quaternion_slerp_core_tb.sv
